/* rtl/core/table_cipher_block_decrypt_defines.svh */
// Assertion macros shared by the block decryptor RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef TABLE_CIPHER_BLOCK_DECRYPT_DEFINES_SVH
`define TABLE_CIPHER_BLOCK_DECRYPT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tcbd_pkg.sv */
// Shared types and constants of the table-driven block decryptor.
// Depends on nothing; used by the key store and the top level.
`timescale 1ns / 1ps

package tcbd_pkg;

	localparam logic [1:0] OP_DECRYPT = 2'd0;
	localparam logic [1:0] OP_TABLE   = 2'd1;
	localparam logic [1:0] OP_KEY     = 2'd2;

	localparam int LANES   = 16;
	localparam int WORDS   = 4;
	localparam int ENTRIES = 256;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 32;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Byte positions read by each output word in the row-shifted rounds.
	localparam logic [3:0] SHIFTED_LANE [LANES] = '{
		4'd0, 4'd7, 4'd10, 4'd13,
		4'd1, 4'd4, 4'd11, 4'd14,
		4'd2, 4'd5, 4'd8,  4'd15,
		4'd3, 4'd6, 4'd9,  4'd12
	};

	// Write of one round-key word.
	typedef struct packed {
		logic       en;
		logic [1:0] bank;
		logic [4:0] round;
		word_t      data;
	} key_wr_t;

endpackage

/* rtl/core/tcbd_req_if.sv */
// Request channel of the block decryptor: handshake and request fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcbd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [4:0]  round_index;
	logic [3:0]  lane;
	logic [7:0]  byte_value;
	logic [31:0] load_word;

	modport source (output valid, op, block_low, block_high, round_index, lane,
		byte_value, load_word, input ready);
	modport sink (input valid, op, block_low, block_high, round_index, lane,
		byte_value, load_word, output ready);
endinterface

/* rtl/core/tcbd_rsp_if.sv */
// Result channel of the block decryptor: handshake and plaintext fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcbd_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_low;
	logic [63:0] plain_high;

	modport source (output valid, plain_low, plain_high, input ready);
	modport sink (input valid, plain_low, plain_high, output ready);
endinterface

/* rtl/core/tcbd_lane_mem.sv */
// One byte position's lookup tables for all rounds: a simple dual-port RAM
// with registered read data. Depends on nothing.
`timescale 1ns / 1ps

module tcbd_lane_mem #(
	parameter int DEPTH  = 4352,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/tcbd_key_mem.sv */
// Round-key store: four banks, one per key word, each holding one word per
// round, read together with registered data. Depends on tcbd_pkg.
`timescale 1ns / 1ps

module tcbd_key_mem #(
	parameter int ROUNDS = 17,
	parameter int RW     = 5
) (
	input  logic             clk,
	input  tcbd_pkg::key_wr_t wr,
	input  logic             rd_en,
	input  logic [RW-1:0]    rd_round,
	output tcbd_pkg::word_t  rd_data [tcbd_pkg::WORDS]
);
	import tcbd_pkg::*;

	for (genvar w = 0; w < WORDS; w++) begin : g_bank
		word_t mem [0:ROUNDS-1];

		always_ff @(posedge clk) begin
			if (wr.en && wr.bank == 2'(w)) begin
				mem[wr.round[RW-1:0]] <= wr.data;
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rd_data[w] <= mem[rd_round];
			end
		end
	end

endmodule

/* rtl/core/table_cipher_block_decrypt.sv */
// Table-driven block decryptor. A decrypt request runs one round per cycle
// from acceptance to a valid result, unless held in its last round: each
// round reads all sixteen lane tables at once, and the next round's table
// addresses come from this round's read data, so the registered table read
// sets the pace. A new decrypt is taken in the cycle after the previous one
// finishes, not before; table and key loads are taken one per cycle while
// no decrypt is running. The result waits in an output register, and the
// block holds in its last round only if that register is full and not taken.
`timescale 1ns / 1ps
`include "table_cipher_block_decrypt_defines.svh"

module table_cipher_block_decrypt #(
	parameter int ROUNDS = 17
) (
	input logic         clk,
	input logic         arst_n,
	tcbd_req_if.sink    req,
	tcbd_rsp_if.source  rsp
);
	import tcbd_pkg::*;

	localparam int RW     = $clog2(ROUNDS);
	localparam int ADDR_W = RW + BYTE_W;
	localparam int DEPTH  = ROUNDS * ENTRIES;

	logic          busy_q;
	logic [RW-1:0] rnd_q;
	logic          out_valid_q;
	logic [63:0]   plain_low_q;
	logic [63:0]   plain_high_q;

	logic          accept;
	logic          start;
	logic          round_ok;
	logic          last;
	logic          hold;
	logic          advance;
	logic          finish;
	logic          straight;
	logic          rd_en;
	logic [RW-1:0] rd_round;

	byte_t   in_byte   [LANES];
	byte_t   next_byte [LANES];
	word_t   tbl_data  [LANES];
	word_t   key_data  [WORDS];
	word_t   acc       [WORDS];
	key_wr_t key_wr;

	assign accept   = req.valid && req.ready;
	assign start    = accept && req.op == OP_DECRYPT;
	assign round_ok = int'(req.round_index) < ROUNDS;
	assign last     = rnd_q == RW'(ROUNDS - 1);
	assign hold     = busy_q && last && out_valid_q && !rsp.ready;
	assign advance  = busy_q && !hold;
	assign finish   = advance && last;
	assign straight = rnd_q < RW'(2) || last;

	// Loads and decrypts never overlap, so a table entry is never written
	// while a round is reading it.
	assign req.ready = !busy_q;

	// While idle the tables are read with round zero and the offered block,
	// so the first round's data is ready the cycle after acceptance.
	assign rd_en    = !busy_q || (advance && !last);
	assign rd_round = busy_q ? rnd_q + 1'b1 : '0;

	for (genvar p = 0; p < LANES / 2; p++) begin : g_unpack
		assign in_byte[p]             = req.block_low[BYTE_W*p +: BYTE_W];
		assign in_byte[p + LANES / 2] = req.block_high[BYTE_W*p +: BYTE_W];
	end

	for (genvar p = 0; p < LANES; p++) begin : g_lane
		logic we;

		assign we = accept && req.op == OP_TABLE && round_ok && req.lane == 4'(p);

		tcbd_lane_mem #(
			.DEPTH  (DEPTH),
			.ADDR_W (ADDR_W)
		) u_lane_mem (
			.clk     (clk),
			.we      (we),
			.wr_addr ({req.round_index[RW-1:0], req.byte_value}),
			.wr_data (req.load_word),
			.rd_en   (rd_en),
			.rd_addr ({rd_round, busy_q ? next_byte[p] : in_byte[p]}),
			.rd_data (tbl_data[p])
		);
	end

	assign key_wr.en    = accept && req.op == OP_KEY && round_ok && int'(req.lane) < WORDS;
	assign key_wr.bank  = req.lane[1:0];
	assign key_wr.round = req.round_index;
	assign key_wr.data  = req.load_word;

	tcbd_key_mem #(
		.ROUNDS (ROUNDS),
		.RW     (RW)
	) u_key_mem (
		.clk      (clk),
		.wr       (key_wr),
		.rd_en    (rd_en),
		.rd_round (rd_round),
		.rd_data  (key_data)
	);

	// Each output word folds four lane lookups into the round key; only the
	// choice of lanes differs between straight and row-shifted rounds.
	always_comb begin
		for (int w = 0; w < WORDS; w++) begin
			acc[w] = key_data[w];
			for (int k = 0; k < 4; k++) begin
				acc[w] = acc[w] ^ tbl_data[straight ? 4'(4 * w + k) : SHIFTED_LANE[4 * w + k]];
			end
		end
	end

	for (genvar w = 0; w < WORDS; w++) begin : g_split
		for (genvar k = 0; k < 4; k++) begin : g_byte
			assign next_byte[4 * w + k] = acc[w][BYTE_W*k +: BYTE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				rnd_q  <= '0;
			end else if (advance) begin
				rnd_q <= rnd_q + 1'b1;
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			for (int i = 0; i < LANES / 2; i++) begin
				plain_low_q[BYTE_W*i +: BYTE_W]  <= next_byte[i];
				plain_high_q[BYTE_W*i +: BYTE_W] <= next_byte[i + LANES / 2];
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.plain_low  = plain_low_q;
	assign rsp.plain_high = plain_high_q;

	`TCBD_ASSERT_IMP(a_no_request_while_busy, clk, arst_n, busy_q, !req.ready, "request taken during a decrypt")
	`TCBD_ASSERT_NEXT(a_start_round_zero, clk, arst_n, start, busy_q && rnd_q == '0, "decrypt did not start at round zero")
	`TCBD_ASSERT_NEXT(a_round_steps, clk, arst_n, advance && !last, busy_q && rnd_q == RW'($past(rnd_q) + 1'b1), "round counter did not step by one")
	`TCBD_ASSERT_NEXT(a_finish_emits, clk, arst_n, finish, rsp.valid && !busy_q, "last round did not produce a result")
	`TCBD_ASSERT_IMP(a_hold_only_full, clk, arst_n, busy_q && !advance, last && out_valid_q, "round stalled without a full output register")

endmodule

/* sim/tcbd_plaintext_checker.sv */
// Checker for the table-driven block decryptor: watches both channels,
// keeps its own copy of the lookup tables and round keys, and compares plaintext.
// Depends on tcbd_pkg and the tcbd_req_if / tcbd_rsp_if interfaces.
`timescale 1ns / 1ps

module tcbd_plaintext_checker #(
	parameter int ROUNDS = 17
) (
	input  logic  clk,
	input  logic  arst_n,
	tcbd_req_if   req,
	tcbd_rsp_if   rsp,
	output int    fail_count,
	output int    outstanding
);
	import tcbd_pkg::*;

	typedef struct packed {
		logic [63:0] plain_low;
		logic [63:0] plain_high;
	} plain_t;

	plain_t expected_plain [$];
	word_t  lut [ROUNDS][LANES][ENTRIES];
	word_t  round_key [ROUNDS*WORDS];
	int     mismatches = 0;
	plain_t want;

	function automatic plain_t decipher(input logic [63:0] lo, input logic [63:0] hi);
		byte_t      cur [LANES];
		word_t      mixed [WORDS];
		plain_t     res;
		logic [3:0] src;
		bit         straight;
		for (int i = 0; i < 8; i++) begin
			cur[i]     = lo[8*i +: 8];
			cur[i + 8] = hi[8*i +: 8];
		end
		for (int r = 0; r < ROUNDS; r++) begin
			// The first two rounds and the last one read their bytes in order.
			straight = (r < 2) || (r == ROUNDS - 1);
			for (int w = 0; w < WORDS; w++) begin
				mixed[w] = round_key[r*WORDS + w];
				for (int k = 0; k < 4; k++) begin
					src = straight ? 4'(w*4 + k) : SHIFTED_LANE[w*4 + k];
					mixed[w] ^= lut[r][src][cur[src]];
				end
			end
			for (int w = 0; w < WORDS; w++)
				for (int k = 0; k < 4; k++)
					cur[w*4 + k] = mixed[w][8*k +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			res.plain_low[8*i +: 8]  = cur[i];
			res.plain_high[8*i +: 8] = cur[i + 8];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_plain.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				case (req.op)
					OP_TABLE: begin
						if (req.round_index < ROUNDS)
							lut[req.round_index][req.lane][req.byte_value] = req.load_word;
					end
					OP_KEY: begin
						if (req.round_index < ROUNDS && req.lane < WORDS)
							round_key[req.round_index*WORDS + req.lane] = req.load_word;
					end
					OP_DECRYPT: begin
						expected_plain.push_back(decipher(req.block_low, req.block_high));
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_plain.size() == 0) begin
					mismatches++;
					$display("%0t: plaintext with no request pending: expected none, actual %h %h",
						$time, rsp.plain_high, rsp.plain_low);
				end else begin
					want = expected_plain.pop_front();
					if (want.plain_low !== rsp.plain_low) begin
						mismatches++;
						$display("%0t: plain_low mismatch: expected %h, actual %h",
							$time, want.plain_low, rsp.plain_low);
					end
					if (want.plain_high !== rsp.plain_high) begin
						mismatches++;
						$display("%0t: plain_high mismatch: expected %h, actual %h",
							$time, want.plain_high, rsp.plain_high);
					end
				end
			end
			fail_count  <= mismatches;
			outstanding <= expected_plain.size();
		end
	end
endmodule

/* sim/tb_table_cipher_block_decrypt.sv */
// Top of the block decryptor testbench: clock, reset, request and result drivers.
// Loads the reachable table entries and every round key, then runs directed and random requests.
// Depends on tcbd_pkg, the channel interfaces, the block and tcbd_plaintext_checker.
`timescale 1ns / 1ps

module tb_table_cipher_block_decrypt;
	import tcbd_pkg::*;

	localparam int         ROUNDS       = 17;
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         RANDOM_ITEMS = 250;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         SPAN_SIZE    = 4;
	// These byte values are closed under XOR.
	localparam logic [7:0] SPAN [SPAN_SIZE] = '{8'h00, 8'h5a, 8'ha5, 8'hff};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm      = 1'b0;
	bit   hold_ask  = 1'b0;
	int   fail_count;
	int   outstanding;
	int   cycles = 0;

	tcbd_req_if req_ch ();
	tcbd_rsp_if rsp_ch ();

	table_cipher_block_decrypt #(.ROUNDS(ROUNDS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tcbd_plaintext_checker #(.ROUNDS(ROUNDS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [7:0] span_byte();
		return SPAN[$urandom_range(0, SPAN_SIZE - 1)];
	endfunction

	function automatic logic [31:0] span_word();
		return {span_byte(), span_byte(), span_byte(), span_byte()};
	endfunction

	function automatic logic [63:0] span_block();
		return {span_word(), span_word()};
	endfunction

	// The last round's output indexes nothing, so its words may take any value.
	function automatic logic [31:0] load_value(input int r);
		return (r == ROUNDS - 1) ? $urandom() : span_word();
	endfunction

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_request(input logic [1:0] op, input logic [63:0] lo,
		input logic [63:0] hi, input logic [4:0] rnd, input logic [3:0] ln,
		input logic [7:0] bv, input logic [31:0] wd, input bit may_gap);
		int gap;
		if (may_gap && !calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.block_low   <= lo;
		req_ch.block_high  <= hi;
		req_ch.round_index <= rnd;
		req_ch.lane        <= ln;
		req_ch.byte_value  <= bv;
		req_ch.load_word   <= wd;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic random_decrypt();
		send_request(OP_DECRYPT, span_block(), span_block(), 5'($urandom), 4'($urandom),
			8'($urandom), $urandom(), 1'b1);
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				// Long hold-off so that the block fills up and stalls its input.
				hold_ask = 1'b0;
				stall_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("table_cipher_block_decrypt test failed");
		$finish;
	end

	initial begin : stimulus
		int  count;
		int  pick;
		int  idx;
		int  rr;
		bit  midway_done;
		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_DECRYPT;
		req_ch.block_low   <= '0;
		req_ch.block_high  <= '0;
		req_ch.round_index <= '0;
		req_ch.lane        <= '0;
		req_ch.byte_value  <= '0;
		req_ch.load_word   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Blocks, and table and key words below the last round, use only bytes
		// from a set closed under XOR, so each table is looked up at just four
		// entries. Those entries and every key word are written before any decrypt.
		idx = 0;
		for (int r = 0; r < ROUNDS; r++)
			for (int l = 0; l < LANES; l++)
				for (int b = 0; b < SPAN_SIZE; b++) begin
					send_request(OP_TABLE, rand64(), rand64(), 5'(r), 4'(l), SPAN[b],
						load_value(r), idx % 16 == 0);
					idx++;
				end
		for (int r = 0; r < ROUNDS; r++)
			for (int w = 0; w < WORDS; w++)
				send_request(OP_KEY, rand64(), rand64(), 5'(r), 4'(w), 8'($urandom),
					load_value(r), 1'b1);

		// Directed requests: extreme blocks and words, ignored loads, unused op.
		send_request(OP_DECRYPT, '0, '0, '0, '0, '0, '0, 1'b1);
		send_request(OP_DECRYPT, '1, '1, '1, '1, '1, '1, 1'b1);
		send_request(OP_DECRYPT, 64'hffa55a00ff5aa500, 64'h00ff5aa5a55aff00,
			'0, '0, '0, '0, 1'b1);
		send_request(OP_UNUSED, '1, '1, '1, '1, '1, '1, 1'b1);
		send_request(OP_TABLE, '0, '0, 5'd17, 4'd15, 8'd255, '1, 1'b1);
		send_request(OP_TABLE, '1, '1, 5'd31, 4'd0, 8'd0, $urandom(), 1'b1);
		send_request(OP_KEY, '0, '0, 5'd0, 4'd4, '0, '1, 1'b1);
		send_request(OP_KEY, '0, '0, 5'd16, 4'd15, '0, '1, 1'b1);
		send_request(OP_KEY, '0, '0, 5'd31, 4'd3, '0, '1, 1'b1);
		send_request(OP_KEY, '0, '0, 5'd17, 4'd0, '0, '1, 1'b1);
		send_request(OP_TABLE, '0, '0, 5'd0, 4'd0, 8'd0, '0, 1'b1);
		send_request(OP_TABLE, '0, '0, 5'd16, 4'd15, 8'd255, '1, 1'b1);
		send_request(OP_KEY, '0, '0, 5'd0, 4'd0, '0, '0, 1'b1);
		send_request(OP_KEY, '0, '0, 5'd16, 4'd3, '0, '1, 1'b1);
		send_request(OP_DECRYPT, '0, '0, '0, '0, '0, '0, 1'b1);
		send_request(OP_DECRYPT, '1, '1, '0, '0, '0, '0, 1'b1);
		send_request(OP_DECRYPT, '1, '0, '0, '0, '0, '0, 1'b1);
		send_request(OP_DECRYPT, '0, '1, '0, '0, '0, '0, 1'b1);
		wait_for_results();

		hold_ask = 1'b1;
		for (int i = 0; i < 6; i++)
			random_decrypt();
		wait_for_results();

		count = 0;
		midway_done = 1'b0;
		while (count < RANDOM_ITEMS) begin
			if (count >= RANDOM_ITEMS * 17 / 20)
				calm = 1'b1;
			if (!midway_done && count >= RANDOM_ITEMS / 2) begin
				midway_done = 1'b1;
				wait_for_results();
			end
			pick = $urandom_range(0, 19);
			if (pick < 10) begin
				random_decrypt();
				count++;
			end else if (pick < 16) begin
				rr = $urandom_range(0, ROUNDS - 1);
				send_request(OP_TABLE, rand64(), rand64(), 5'(rr),
					4'($urandom), 8'($urandom), load_value(rr), 1'b1);
				count++;
			end else if (pick < 18) begin
				rr = $urandom_range(0, ROUNDS - 1);
				send_request(OP_KEY, rand64(), rand64(), 5'(rr),
					4'($urandom_range(0, WORDS - 1)), 8'($urandom), load_value(rr), 1'b1);
				count++;
			end else begin
				// Requests the block must drop without touching its state.
				case ($urandom_range(0, 2))
					0: send_request(OP_UNUSED, rand64(), rand64(), 5'($urandom),
						4'($urandom), 8'($urandom), $urandom(), 1'b1);
					1: send_request(OP_TABLE, rand64(), rand64(), 5'($urandom_range(ROUNDS, 31)),
						4'($urandom), 8'($urandom), $urandom(), 1'b1);
					default: send_request(OP_KEY, rand64(), rand64(), 5'($urandom),
						4'($urandom_range(WORDS, 15)), 8'($urandom), $urandom(), 1'b1);
				endcase
			end
		end

		wait_for_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("table_cipher_block_decrypt test passed");
		end else begin
			$display("table_cipher_block_decrypt test failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcbd_pkg.sv
rtl/core/tcbd_req_if.sv
rtl/core/tcbd_rsp_if.sv
rtl/core/tcbd_lane_mem.sv
rtl/core/tcbd_key_mem.sv
rtl/core/table_cipher_block_decrypt.sv
sim/tcbd_plaintext_checker.sv
sim/tb_table_cipher_block_decrypt.sv
